// ----- src/lfps_pkg.sv -----
// shared types, constants and register codes of the line follower steering block
// used by every module of the block and by the channel interfaces
package lfps_pkg;

	localparam int SENSOR_COUNT   = 8;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int REFL_FIELDS    = 8;
	localparam int SUM_COUNT      = (SENSOR_COUNT < REFL_FIELDS) ? SENSOR_COUNT : REFL_FIELDS;

	localparam int REFL_W    = 10;
	localparam int POS_W     = 13;
	localparam int LIM_W     = 13;
	localparam int SPEED_W   = 8;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int SUM_W = $clog2(SUM_COUNT * ((1 << REFL_W) - 1) + 1);
	localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

	localparam int ERR_W   = POS_W + 1;
	localparam int DER_W   = ERR_W + 1;
	localparam int ACC_W   = 32;
	localparam int PP_W    = GAIN_W + ERR_W;
	localparam int PI_W    = GAIN_W + ACC_W;
	localparam int PD_W    = GAIN_W + DER_W;
	localparam int TOT_W   = PI_W + 2;
	localparam int CORR_W  = 16;
	localparam int WHEEL_W = CORR_W + 2;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_LOW    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_HIGH   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd7;

	localparam logic signed [GAIN_W-1:0] RST_GAIN_PROP  = 16'sd26;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_INTEG = 16'sd0;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_DERIV = 16'sd128;
	localparam logic [SPEED_W-1:0]       RST_BASE_SPEED = 8'd150;
	localparam logic [SPEED_W-1:0]       RST_SPEED_CAP  = 8'd255;
	localparam logic [LIM_W-1:0]         RST_SUM_LOW    = 13'd1000;
	localparam logic [LIM_W-1:0]         RST_SUM_HIGH   = 13'd4500;
	localparam logic [POS_W-1:0]         RST_CENTER     = 13'd3500;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_prop;
		logic signed [GAIN_W-1:0] gain_integ;
		logic signed [GAIN_W-1:0] gain_deriv;
		logic [SPEED_W-1:0]       base_speed;
		logic [SPEED_W-1:0]       speed_cap;
		logic [LIM_W-1:0]         sum_low_limit;
		logic [LIM_W-1:0]         sum_high_limit;
		logic [POS_W-1:0]         center_position;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]  line_position;
		logic [REFL_W-1:0] refl_0;
		logic [REFL_W-1:0] refl_1;
		logic [REFL_W-1:0] refl_2;
		logic [REFL_W-1:0] refl_3;
		logic [REFL_W-1:0] refl_4;
		logic [REFL_W-1:0] refl_5;
		logic [REFL_W-1:0] refl_6;
		logic [REFL_W-1:0] refl_7;
	} sensor_t;

	typedef struct packed {
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
		logic               halted;
	} drive_t;

	typedef struct packed {
		logic                    halt;
		logic signed [ERR_W-1:0] err;
	} q_entry_t;

	typedef struct packed {
		logic     empty;
		logic     full;
		q_entry_t head;
	} q_status_t;

endpackage

// ----- src/lfps_sensor_if.sv -----
// sensor frame channel: valid, ready and one sensor frame
// depends on lfps_pkg for the payload type
interface lfps_sensor_if;
	logic             valid;
	logic             ready;
	lfps_pkg::sensor_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/lfps_drive_if.sv -----
// wheel command channel: valid, ready and one pair of wheel speeds
// depends on lfps_pkg for the payload type
interface lfps_drive_if;
	logic            valid;
	logic            ready;
	lfps_pkg::drive_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/line_follow_pid_steer.sv -----
// top level of the line follower pid steering block
// depends on lfps_pkg, lfps_sensor_if, lfps_drive_if and the lfps_* modules
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  sensor   | in  | valid / ready | line_position, refl_0 .. refl_7
//  drive    | out | valid / ready | left_speed, right_speed, halted
//  cfg      | in  | cfg_we        | cfg_addr register index, cfg_data value
//
// one frame a cycle sustained while the drive channel takes commands; a frame's
// command passes through its queue entry, then three back end stages and the
// output register
// reset clears the queue, the pipeline valids, the integral and the last error,
// and loads the register defaults
// a stalled drive channel holds the whole back end; the two-entry queue fills
// and then sensor ready drops
module line_follow_pid_steer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfps_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [lfps_pkg::CFG_W-1:0]     cfg_data,
	lfps_sensor_if.sink                    sensor,
	lfps_drive_if.source                   drive
);

	lfps_pkg::cfg_t      cfg;
	lfps_pkg::q_entry_t  entry;
	lfps_pkg::q_status_t q_status;
	logic                push;
	logic                pop;

	lfps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lfps_front u_front (
		.sensor (sensor),
		.cfg    (cfg),
		.q_full (q_status.full),
		.push   (push),
		.entry  (entry)
	);

	lfps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.status (q_status)
	);

	lfps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.q      (q_status),
		.pop    (pop),
		.drive  (drive)
	);

endmodule

// ----- src/lfps_cfg.sv -----
// configuration register bank, written through a plain write port
// depends on lfps_pkg for register codes, reset values and cfg_t
module lfps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [lfps_pkg::CFG_IDX_W-1:0] addr,
	input  logic [lfps_pkg::CFG_W-1:0]     data,
	output lfps_pkg::cfg_t                 cfg
);

	lfps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop       <= lfps_pkg::RST_GAIN_PROP;
			cfg_q.gain_integ      <= lfps_pkg::RST_GAIN_INTEG;
			cfg_q.gain_deriv      <= lfps_pkg::RST_GAIN_DERIV;
			cfg_q.base_speed      <= lfps_pkg::RST_BASE_SPEED;
			cfg_q.speed_cap       <= lfps_pkg::RST_SPEED_CAP;
			cfg_q.sum_low_limit   <= lfps_pkg::RST_SUM_LOW;
			cfg_q.sum_high_limit  <= lfps_pkg::RST_SUM_HIGH;
			cfg_q.center_position <= lfps_pkg::RST_CENTER;
		end else if (we) begin
			case (addr)
				lfps_pkg::REG_GAIN_PROP: begin
					cfg_q.gain_prop <= data[lfps_pkg::GAIN_W-1:0];
				end
				lfps_pkg::REG_GAIN_INTEG: begin
					cfg_q.gain_integ <= data[lfps_pkg::GAIN_W-1:0];
				end
				lfps_pkg::REG_GAIN_DERIV: begin
					cfg_q.gain_deriv <= data[lfps_pkg::GAIN_W-1:0];
				end
				lfps_pkg::REG_BASE_SPEED: begin
					cfg_q.base_speed <= data[lfps_pkg::SPEED_W-1:0];
				end
				lfps_pkg::REG_SPEED_CAP: begin
					cfg_q.speed_cap <= data[lfps_pkg::SPEED_W-1:0];
				end
				lfps_pkg::REG_SUM_LOW: begin
					cfg_q.sum_low_limit <= data[lfps_pkg::LIM_W-1:0];
				end
				lfps_pkg::REG_SUM_HIGH: begin
					cfg_q.sum_high_limit <= data[lfps_pkg::LIM_W-1:0];
				end
				lfps_pkg::REG_CENTER: begin
					cfg_q.center_position <= data[lfps_pkg::POS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/lfps_front.sv -----
// front end: takes sensor frames, sums the reflectances, checks the window
// and forms the position error; depends on lfps_pkg and lfps_sensor_if
module lfps_front (
	lfps_sensor_if.sink            sensor,
	input  lfps_pkg::cfg_t         cfg,
	input  logic                   q_full,
	output logic                   push,
	output lfps_pkg::q_entry_t     entry
);

	logic [lfps_pkg::REFL_W-1:0] refl [lfps_pkg::REFL_FIELDS];
	logic [lfps_pkg::SUM_W-1:0]  sum;
	logic [lfps_pkg::CMP_W-1:0]  sum_c;

	assign refl[0] = sensor.data.refl_0;
	assign refl[1] = sensor.data.refl_1;
	assign refl[2] = sensor.data.refl_2;
	assign refl[3] = sensor.data.refl_3;
	assign refl[4] = sensor.data.refl_4;
	assign refl[5] = sensor.data.refl_5;
	assign refl[6] = sensor.data.refl_6;
	assign refl[7] = sensor.data.refl_7;

	always_comb begin
		sum = '0;
		for (int i = 0; i < lfps_pkg::SUM_COUNT; i++) begin
			sum = sum + lfps_pkg::SUM_W'(refl[i]);
		end
	end

	assign sum_c = lfps_pkg::CMP_W'(sum);

	assign sensor.ready = !q_full;
	assign push         = sensor.valid && !q_full;

	assign entry.halt = (sum_c < lfps_pkg::CMP_W'(cfg.sum_low_limit)) ||
		(sum_c > lfps_pkg::CMP_W'(cfg.sum_high_limit));
	assign entry.err  = $signed({1'b0, cfg.center_position}) -
		$signed({1'b0, sensor.data.line_position});

endmodule

// ----- src/lfps_queue.sv -----
// short queue of classified frames between front and back end
// depends on lfps_pkg for the entry and status types
module lfps_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lfps_pkg::q_entry_t  entry,
	input  logic                pop,
	output lfps_pkg::q_status_t status
);

	lfps_pkg::q_entry_t              mem_q [lfps_pkg::Q_DEPTH];
	logic [lfps_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [lfps_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [lfps_pkg::Q_CNT_W-1:0]    cnt_q;

	function automatic logic [lfps_pkg::Q_PTR_W-1:0] ptr_next(
		input logic [lfps_pkg::Q_PTR_W-1:0] p
	);
		if (p == lfps_pkg::Q_PTR_W'(lfps_pkg::Q_DEPTH - 1)) begin
			return '0;
		end
		return p + lfps_pkg::Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + lfps_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - lfps_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == lfps_pkg::Q_CNT_W'(lfps_pkg::Q_DEPTH));
	assign status.head  = mem_q[rd_ptr_q];

endmodule

// ----- src/lfps_back.sv -----
// back end: pid update with saturating integral, gain products, rounding
// toward zero and wheel clamps; depends on lfps_pkg and lfps_drive_if
module lfps_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lfps_pkg::cfg_t      cfg,
	input  lfps_pkg::q_status_t q,
	output logic                pop,
	lfps_drive_if.source        drive
);

	localparam int F = lfps_pkg::GAIN_FRAC_BITS;
	localparam logic signed [lfps_pkg::TOT_W-1:0] CORR_MAX =
		lfps_pkg::TOT_W'((1 << (lfps_pkg::CORR_W - 1)) - 1);
	localparam logic signed [lfps_pkg::TOT_W-1:0] CORR_MIN = -CORR_MAX - lfps_pkg::TOT_W'(1);
	localparam logic signed [lfps_pkg::TOT_W-1:0] ROUND_BIAS = lfps_pkg::TOT_W'((1 << F) - 1);
	localparam logic signed [lfps_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(lfps_pkg::ACC_W-1){1'b1}}};
	localparam logic signed [lfps_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(lfps_pkg::ACC_W-1){1'b0}}};

	logic                               adv;
	logic signed [lfps_pkg::ACC_W-1:0]  accum_q;
	logic signed [lfps_pkg::ERR_W-1:0]  prev_err_q;
	logic signed [lfps_pkg::ACC_W:0]    acc_sum;
	logic signed [lfps_pkg::ACC_W-1:0]  acc_next;
	logic signed [lfps_pkg::DER_W-1:0]  der_next;

	logic                               valid_s1, valid_s2, valid_s3;
	logic                               halt_s1, halt_s2, halt_s3;
	logic signed [lfps_pkg::ERR_W-1:0]  err_s1;
	logic signed [lfps_pkg::ACC_W-1:0]  acc_s1;
	logic signed [lfps_pkg::DER_W-1:0]  der_s1;
	logic signed [lfps_pkg::PP_W-1:0]   pp_s2;
	logic signed [lfps_pkg::PI_W-1:0]   pi_s2;
	logic signed [lfps_pkg::PD_W-1:0]   pd_s2;
	logic signed [lfps_pkg::TOT_W-1:0]  total_s3;

	logic signed [lfps_pkg::TOT_W-1:0]  biased;
	logic signed [lfps_pkg::TOT_W-1:0]  shifted;
	logic signed [lfps_pkg::CORR_W-1:0] corr;
	logic signed [lfps_pkg::WHEEL_W-1:0] base_w;
	logic signed [lfps_pkg::WHEEL_W-1:0] left_w;
	logic signed [lfps_pkg::WHEEL_W-1:0] right_w;

	logic                               out_valid_q;
	lfps_pkg::drive_t                   out_q;

	function automatic logic [lfps_pkg::SPEED_W-1:0] wheel_clamp(
		input logic signed [lfps_pkg::WHEEL_W-1:0] v,
		input logic [lfps_pkg::SPEED_W-1:0]        mx
	);
		if (v < 0) begin
			return '0;
		end
		if (v > $signed(lfps_pkg::WHEEL_W'(mx))) begin
			return mx;
		end
		return v[lfps_pkg::SPEED_W-1:0];
	endfunction

	assign adv = !out_valid_q || drive.ready;
	assign pop = !q.empty && adv;

	// saturating integral and derivative for the head entry
	always_comb begin
		acc_sum = (lfps_pkg::ACC_W+1)'(accum_q) + (lfps_pkg::ACC_W+1)'(q.head.err);
		if (acc_sum[lfps_pkg::ACC_W] != acc_sum[lfps_pkg::ACC_W-1]) begin
			acc_next = acc_sum[lfps_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_next = acc_sum[lfps_pkg::ACC_W-1:0];
		end
		der_next = lfps_pkg::DER_W'(q.head.err) - lfps_pkg::DER_W'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			prev_err_q  <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (pop && !q.head.halt) begin
				accum_q    <= acc_next;
				prev_err_q <= q.head.err;
			end
		end
	end

	// truncation toward zero, then 16-bit saturation
	always_comb begin
		biased  = total_s3[lfps_pkg::TOT_W-1] ? (total_s3 + ROUND_BIAS) : total_s3;
		shifted = biased >>> F;
		if (shifted > CORR_MAX) begin
			corr = CORR_MAX[lfps_pkg::CORR_W-1:0];
		end else if (shifted < CORR_MIN) begin
			corr = CORR_MIN[lfps_pkg::CORR_W-1:0];
		end else begin
			corr = shifted[lfps_pkg::CORR_W-1:0];
		end
		base_w  = $signed(lfps_pkg::WHEEL_W'(cfg.base_speed));
		left_w  = base_w - lfps_pkg::WHEEL_W'(corr);
		right_w = base_w + lfps_pkg::WHEEL_W'(corr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pop) begin
				halt_s1 <= q.head.halt;
				err_s1  <= q.head.err;
				acc_s1  <= acc_next;
				der_s1  <= der_next;
			end
			halt_s2  <= halt_s1;
			pp_s2    <= lfps_pkg::PP_W'(err_s1) * lfps_pkg::PP_W'(cfg.gain_prop);
			pi_s2    <= lfps_pkg::PI_W'(acc_s1) * lfps_pkg::PI_W'(cfg.gain_integ);
			pd_s2    <= lfps_pkg::PD_W'(der_s1) * lfps_pkg::PD_W'(cfg.gain_deriv);
			halt_s3  <= halt_s2;
			total_s3 <= lfps_pkg::TOT_W'(pp_s2) + lfps_pkg::TOT_W'(pi_s2) +
				lfps_pkg::TOT_W'(pd_s2);
			if (halt_s3) begin
				out_q.left_speed  <= '0;
				out_q.right_speed <= '0;
				out_q.halted      <= 1'b1;
			end else begin
				out_q.left_speed  <= wheel_clamp(left_w, cfg.speed_cap);
				out_q.right_speed <= wheel_clamp(right_w, cfg.speed_cap);
				out_q.halted      <= 1'b0;
			end
		end
	end

	assign drive.valid = out_valid_q;
	assign drive.data  = out_q;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for line_follow_pid_steer: directed and random sensor frames,
// register settings between phases, a cycle-free predictor and a command scoreboard
// depends on lfps_pkg, lfps_sensor_if, lfps_drive_if and the block's rtl
module testbench;
	import lfps_pkg::*;

	localparam int PIPE_LATENCY = 4;
	localparam int REFL_MAX     = (1 << REFL_W) - 1;
	localparam int SUM_MAX      = REFL_FIELDS * REFL_MAX;
	localparam int POS_MAX      = (1 << POS_W) - 1;
	localparam int LIM_MAX      = (1 << LIM_W) - 1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_data;

	lfps_sensor_if sensor_ch();
	lfps_drive_if drive_ch();

	line_follow_pid_steer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.sensor(sensor_ch),
		.drive(drive_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cfg_t model_cfg;
	logic signed [31:0] integ_sum;
	logic signed [15:0] last_err;
	drive_t expected_drive[$];

	int src_idle_pct;
	int rx_idle_pct;
	int fail_count;
	int frames_sent;
	int halts_predicted;
	int settings_written;

	function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// one control update of the steering loop; only a frame inside the window advances the predicted state
	function automatic drive_t steer_predict(input sensor_t f);
		drive_t d;
		logic [13:0] sum;
		longint err, acc, der, total, corr;
		sum = 14'(f.refl_0) + 14'(f.refl_1) + 14'(f.refl_2) + 14'(f.refl_3)
			+ 14'(f.refl_4) + 14'(f.refl_5) + 14'(f.refl_6) + 14'(f.refl_7);
		if (sum < model_cfg.sum_low_limit || sum > model_cfg.sum_high_limit) begin
			halts_predicted++;
			d.left_speed  = '0;
			d.right_speed = '0;
			d.halted      = 1'b1;
			return d;
		end
		err = longint'(model_cfg.center_position) - longint'(f.line_position);
		acc = clamp_l(longint'(integ_sum) + err, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
		der = err - longint'(last_err);
		total = longint'($signed(model_cfg.gain_prop)) * err
			+ longint'($signed(model_cfg.gain_integ)) * acc
			+ longint'($signed(model_cfg.gain_deriv)) * der;
		corr = clamp_l(total / (64'sd1 <<< GAIN_FRAC_BITS), -32768, 32767);
		integ_sum = acc[31:0];
		last_err  = err[15:0];
		d.left_speed  = 8'(clamp_l(longint'(model_cfg.base_speed) - corr, 0,
			longint'(model_cfg.speed_cap)));
		d.right_speed = 8'(clamp_l(longint'(model_cfg.base_speed) + corr, 0,
			longint'(model_cfg.speed_cap)));
		d.halted = 1'b0;
		return d;
	endfunction

	function automatic sensor_t pack_frame(input int pos, input int r [8]);
		return {POS_W'(pos), REFL_W'(r[0]), REFL_W'(r[1]), REFL_W'(r[2]), REFL_W'(r[3]),
			REFL_W'(r[4]), REFL_W'(r[5]), REFL_W'(r[6]), REFL_W'(r[7])};
	endfunction

	// spread a wanted sensor sum over the eight sensors; negative means no wanted sum
	function automatic sensor_t frame_from(input int pos, input int target);
		int r [8];
		int rem, rot, k, lo_k, hi_k, slot;
		rem = target;
		rot = $urandom_range(7);
		for (k = 0; k < 8; k++) begin
			slot = (k + rot) % 8;
			if (target < 0) begin
				r[slot] = $urandom_range(REFL_MAX);
			end else if (k == 7) begin
				r[slot] = rem;
			end else begin
				lo_k = rem - REFL_MAX * (7 - k);
				if (lo_k < 0)
					lo_k = 0;
				hi_k = (rem < REFL_MAX) ? rem : REFL_MAX;
				r[slot] = $urandom_range(hi_k, lo_k);
			end
			if (target >= 0)
				rem -= r[slot];
		end
		return pack_frame(pos, r);
	endfunction

	function automatic sensor_t random_frame();
		int lo, hi, target, pos, pick;
		lo = model_cfg.sum_low_limit;
		hi = (model_cfg.sum_high_limit > SUM_MAX) ? SUM_MAX : model_cfg.sum_high_limit;
		pick = $urandom_range(99);
		if (pick < 70 && lo <= hi) begin
			target = $urandom_range(hi, lo);
		end else if (pick < 85) begin
			case ($urandom_range(3))
				0: target = lo - 1;
				1: target = lo;
				2: target = model_cfg.sum_high_limit;
				default: target = model_cfg.sum_high_limit + 1;
			endcase
			target = int'(clamp_l(target, 0, SUM_MAX));
		end else begin
			target = -1;
		end
		pick = $urandom_range(99);
		if (pick < 80)
			pos = $urandom_range(7000);
		else if (pick < 90)
			pos = $urandom_range(POS_MAX, 7001);
		else
			pos = int'(clamp_l(longint'(model_cfg.center_position) + $urandom_range(600)
				- 300, 0, POS_MAX));
		return frame_from(pos, target);
	endfunction

	function automatic cfg_t tuning(input int gp, input int gi, input int gd, input int base,
		input int top, input int lo, input int hi, input int centre);
		cfg_t c;
		c.gain_prop       = GAIN_W'(gp);
		c.gain_integ      = GAIN_W'(gi);
		c.gain_deriv      = GAIN_W'(gd);
		c.base_speed      = SPEED_W'(base);
		c.speed_cap       = SPEED_W'(top);
		c.sum_low_limit   = LIM_W'(lo);
		c.sum_high_limit  = LIM_W'(hi);
		c.center_position = POS_W'(centre);
		return c;
	endfunction

	function automatic cfg_t random_tuning();
		cfg_t c;
		int lo;
		case ($urandom_range(3))
			0: begin
				c.gain_prop  = GAIN_W'($urandom());
				c.gain_integ = GAIN_W'($urandom());
				c.gain_deriv = GAIN_W'($urandom());
			end
			1: begin
				c.gain_prop  = GAIN_W'($urandom_range(1023) - 512);
				c.gain_integ = GAIN_W'($urandom_range(63) - 32);
				c.gain_deriv = GAIN_W'($urandom_range(1023) - 512);
			end
			default: begin
				c.gain_prop  = GAIN_W'($urandom_range(100));
				c.gain_integ = GAIN_W'($urandom_range(8));
				c.gain_deriv = GAIN_W'($urandom_range(400));
			end
		endcase
		c.base_speed = SPEED_W'($urandom_range(255));
		c.speed_cap  = ($urandom_range(1)) ? 8'd255 : 8'($urandom_range(255));
		lo = $urandom_range(2500);
		c.sum_low_limit  = LIM_W'(lo);
		c.sum_high_limit = ($urandom_range(9) < 8) ? LIM_W'($urandom_range(LIM_MAX, lo))
			: LIM_W'($urandom_range(LIM_MAX));
		c.center_position = ($urandom_range(9) < 7) ? POS_W'($urandom_range(4000, 3000))
			: POS_W'($urandom_range(POS_MAX));
		return c;
	endfunction

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// unused upper data bits carry junk, the block keeps only the register width
	task automatic write_settings(input cfg_t c);
		put_reg(REG_GAIN_PROP, c.gain_prop);
		put_reg(REG_GAIN_INTEG, c.gain_integ);
		put_reg(REG_GAIN_DERIV, c.gain_deriv);
		put_reg(REG_BASE_SPEED, {8'($urandom()), c.base_speed});
		put_reg(REG_SPEED_CAP, {8'($urandom()), c.speed_cap});
		put_reg(REG_SUM_LOW, {3'($urandom()), c.sum_low_limit});
		put_reg(REG_SUM_HIGH, {3'($urandom()), c.sum_high_limit});
		put_reg(REG_CENTER, {3'($urandom()), c.center_position});
		cfg_we <= 1'b0;
		model_cfg = c;
		settings_written++;
	endtask

	task automatic send_frame(input sensor_t f);
		while ($urandom_range(99) < src_idle_pct) begin
			sensor_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.data  <= f;
		@(posedge clk);
		while (!sensor_ch.ready)
			@(posedge clk);
		frames_sent++;
	endtask

	// sender holds off until every pending command has come back
	task automatic drain_commands();
		sensor_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 3) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		int r [8];
		int i, k;
		send_frame(frame_from(3500, 2000));
		send_frame(frame_from(0, 2000));
		send_frame(frame_from(7000, 2000));
		send_frame(frame_from(POS_MAX, 2000));
		send_frame(frame_from(1000, 1000));
		send_frame(frame_from(1000, 999));
		send_frame(frame_from(1000, 1000));
		send_frame(frame_from(6000, 4500));
		send_frame(frame_from(6000, 4501));
		send_frame(frame_from(2000, 0));
		send_frame(frame_from(2000, SUM_MAX));
		for (i = 0; i < 8; i++) begin
			for (k = 0; k < 8; k++)
				r[k] = 100;
			r[i] = REFL_MAX;
			send_frame(pack_frame($urandom_range(POS_MAX), r));
		end
		drain_commands();
	endtask

	task automatic run_frames(input int n);
		repeat (n) send_frame(random_frame());
		drain_commands();
	endtask

	task automatic test_gain_extremes();
		write_settings(tuning(32767, 32767, 32767, 255, 255, 1000, 4500, 3500));
		run_frames(40);
		write_settings(tuning(-32768, -32768, -32768, 0, 0, 1000, 4500, 3500));
		run_frames(40);
		write_settings(tuning(256, 0, 0, 128, 200, 500, 6000, 3500));
		run_frames(40);
		write_settings(tuning(-32768, 32767, 0, 255, 100, 0, LIM_MAX, 7000));
		run_frames(40);
	endtask

	task automatic test_window_limits();
		write_settings(tuning(26, 1, 128, 150, 255, 0, LIM_MAX, 3500));
		run_frames(30);
		write_settings(tuning(26, 0, 128, 150, 255, LIM_MAX, 0, 3500));
		run_frames(30);
		write_settings(tuning(40, 2, 64, 100, 180, 4000, 4000, 3500));
		run_frames(30);
		write_settings(tuning(26, 0, 128, 150, 255, 800, 6000, 0));
		run_frames(30);
		write_settings(tuning(26, 0, 128, 150, 255, 800, 6000, POS_MAX));
		run_frames(30);
	endtask

	task automatic test_random_tuning(input int n);
		int chunk;
		while (n > 0) begin
			chunk = $urandom_range(150, 50);
			if (chunk > n)
				chunk = n;
			write_settings(random_tuning());
			run_frames(chunk);
			n -= chunk;
		end
	endtask

	initial begin
		drive_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			drive_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : scoreboard
		drive_t want;
		if (arst_n && sensor_ch.valid && sensor_ch.ready)
			expected_drive.push_back(steer_predict(sensor_ch.data));
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (expected_drive.size() == 0) begin
				$error("drive transfer with no command pending");
				fail_count++;
			end else begin
				want = expected_drive.pop_front();
				if (drive_ch.data.left_speed !== want.left_speed) begin
					$error("left_speed expected %0d got %0d", want.left_speed,
						drive_ch.data.left_speed);
					fail_count++;
				end
				if (drive_ch.data.right_speed !== want.right_speed) begin
					$error("right_speed expected %0d got %0d", want.right_speed,
						drive_ch.data.right_speed);
					fail_count++;
				end
				if (drive_ch.data.halted !== want.halted) begin
					$error("halted expected %0d got %0d", want.halted,
						drive_ch.data.halted);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("line_follow_pid_steer: mismatch");
		$finish;
	end

	initial begin
		fail_count       = 0;
		frames_sent      = 0;
		halts_predicted  = 0;
		settings_written = 0;
		model_cfg = tuning(RST_GAIN_PROP, RST_GAIN_INTEG, RST_GAIN_DERIV, RST_BASE_SPEED,
			RST_SPEED_CAP, RST_SUM_LOW, RST_SUM_HIGH, RST_CENTER);
		integ_sum = '0;
		last_err  = '0;
		src_idle_pct = 36;
		rx_idle_pct  = 51;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_addr        <= '0;
		cfg_data        <= '0;
		sensor_ch.valid <= 1'b0;
		sensor_ch.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_gain_extremes();
		test_random_tuning(600);
		src_idle_pct = 51;
		rx_idle_pct  = 36;
		test_window_limits();
		test_random_tuning(500);
		src_idle_pct = 0;
		rx_idle_pct  = 0;
		test_random_tuning(300);

		$display("covered %0d sensor frames, %0d of them safety stops, over %0d settings",
			frames_sent, halts_predicted, settings_written);
		$display("gaps on both channels in both mixes, then a stretch at full rate");
		if (fail_count == 0 && expected_drive.size() == 0)
			$display("line_follow_pid_steer: match");
		else
			$display("line_follow_pid_steer: mismatch");
		$finish;
	end
endmodule

// ----- sim.f -----
src/lfps_pkg.sv
src/lfps_sensor_if.sv
src/lfps_drive_if.sv
src/lfps_cfg.sv
src/lfps_front.sv
src/lfps_queue.sv
src/lfps_back.sv
src/line_follow_pid_steer.sv
tb/testbench.sv
